// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the sorted list RTL.
// Needs signals named clk and rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, skipped while reset is asserted.
`define SAL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SAL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/sal_pkg.sv =====
// Shared constants and types for the sorted list core.
// No dependencies; used by sal_cell and sorted_array_list_core.
package sal_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    // common width for position vs count compares
    localparam int CW       = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 3'd0,
        OP_SORTED   = 3'd1,
        OP_DELETE   = 3'd2,
        OP_LOCATE   = 3'd3,
        OP_RETRIEVE = 3'd4,
        OP_CLEAR    = 3'd5
    } op_t;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2
    } cell_op_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        cell_op_t              op;
        logic                  cmp_en;
        logic [IDX_W-1:0]      target;
        logic [DATA_W-1:0]     data;
    } cell_ctl_t;

endpackage

// ===== rtl/core/sal_cell.sv =====
// One slot of the list: holds an entry, shifts from a neighbor, compares to a key.
// Depends on sal_pkg.
module sal_cell
    import sal_pkg::*;
(
    input  logic              clk,
    input  logic [IDX_W-1:0]  idx,
    input  cell_ctl_t         ctl,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    output logic [DATA_W-1:0] data,
    output logic              lt,
    output logic              eq
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              lt_reg;
    logic              eq_reg;

    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            CELL_INS:
            begin
                if (idx > ctl.target)
                    data_next = left_data;
                else if (idx == ctl.target)
                    data_next = ctl.data;
            end
            CELL_DEL:
            begin
                if (idx >= ctl.target)
                    data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (ctl.cmp_en)
        begin
            lt_reg <= ($signed(data_reg) < $signed(ctl.data));
            eq_reg <= (data_reg == ctl.data);
        end
    end

    assign data = data_reg;
    assign lt   = lt_reg;
    assign eq   = eq_reg;

endmodule

// ===== rtl/core/sorted_array_list_core.sv =====
// Top level of the sorted list core: controller, count and result register.
// Depends on sal_pkg, sal_cell and assert_macros.svh.
//
// Usage: one input beat on s_axis_* is one list operation (insert at
// position, sorted insert, delete, locate, retrieve, clear). Each beat
// returns exactly one result beat on m_axis_* with status, read value,
// position, count and empty flag.
// Entries live in a row of cells; inserts and deletes shift the cells from
// the target position onward by one place, all at once.
// Sequence: sorted insert and locate pass through a compare step (the cells
// compare against the key) and then the execute step (count/encode the
// flags and shift); other operations go straight to the execute step.
// Throughput: the input is not ready during the compare step, set by the
// compare register in each cell; other operations can run back to back.
// A new beat is taken in the cycle the current one finishes.
// Reset: the count clears to zero, the list reads empty; entry contents
// are not cleared and are never read before being written.
// Stall: a finished result waits in the output register; the operation
// behind it waits in the execute step until m_axis_tready frees that slot.
module sorted_array_list_core
    import sal_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] op, [34:3] value, [39:35] position
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [33:2] read_value, [38:34] where, [43:39] count,
    // [44] empty_res, [47:45] zero
    output logic [47:0] m_axis_tdata
);

`include "assert_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [OP_W-1:0]     op_reg;
    logic [DATA_W-1:0]   value_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [CNT_W-1:0]    used_reg;
    logic [CNT_W-1:0]    used_next;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [DATA_W-1:0]   out_rd_reg;
    logic [POS_W-1:0]    out_where_reg;
    logic [POS_W-1:0]    out_count_reg;
    logic                out_empty_reg;

    logic [DATA_W-1:0]   cell_data [CAPACITY];
    logic [CAPACITY-1:0] lt_vec;
    logic [CAPACITY-1:0] eq_vec;
    logic [CAPACITY-1:0] valid_vec;
    cell_ctl_t           ctl;

    logic                in_beat;
    logic                exec_go;
    logic [CNT_W-1:0]    lt_cnt;
    logic                found;
    logic [CW-1:0]       match_idx;
    logic [DATA_W-1:0]   rd_sel;
    logic [CW-1:0]       pos_ext;
    logic [CW-1:0]       used_ext;
    logic                full;

    logic [STATUS_W-1:0] res_status;
    logic [DATA_W-1:0]   res_rd;
    logic [CW-1:0]       res_where;
    cell_op_t            res_cell_op;
    logic [IDX_W-1:0]    res_target;

    // ---------------- cell row ----------------
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        sal_cell u_cell (
            .clk        (clk),
            .idx        (IDX_W'(i)),
            .ctl        (ctl),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .lt         (lt_vec[i]),
            .eq         (eq_vec[i])
        );

        assign valid_vec[i] = (CNT_W'(i) < used_reg);
    end

    // ---------------- handshake ----------------
    assign exec_go       = (state_reg == S_EXEC) && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = (state_reg == S_IDLE) || exec_go;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // ---------------- flag reduction ----------------
    assign lt_cnt   = CNT_W'($countones(lt_vec & valid_vec));
    assign pos_ext  = CW'(pos_reg);
    assign used_ext = CW'(used_reg);
    assign full     = (used_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        found     = 1'b0;
        match_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (eq_vec[i] && valid_vec[i])
            begin
                found     = 1'b1;
                match_idx = CW'(i);
            end
        end
    end

    always_comb
    begin
        rd_sel = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (CW'(i) == pos_ext)
                rd_sel = cell_data[i];
        end
    end

    // ---------------- execute step ----------------
    always_comb
    begin
        res_status  = ST_OK;
        res_rd      = '0;
        res_where   = '0;
        res_cell_op = CELL_HOLD;
        res_target  = '0;
        used_next   = used_reg;
        case (op_t'(op_reg))
            OP_INSERT:
            begin
                if (full)
                    res_status = ST_FULL;
                else if (pos_ext > used_ext)
                    res_status = ST_BAD_POS;
                else
                begin
                    res_cell_op = CELL_INS;
                    res_target  = IDX_W'(pos_ext);
                    res_where   = pos_ext;
                    used_next   = CNT_W'(used_reg + 1'b1);
                end
            end
            OP_SORTED:
            begin
                if (full)
                    res_status = ST_FULL;
                else
                begin
                    res_cell_op = CELL_INS;
                    res_target  = IDX_W'(lt_cnt);
                    res_where   = CW'(lt_cnt);
                    used_next   = CNT_W'(used_reg + 1'b1);
                end
            end
            OP_DELETE:
            begin
                if (pos_ext >= used_ext)
                    res_status = ST_BAD_POS;
                else
                begin
                    res_cell_op = CELL_DEL;
                    res_target  = IDX_W'(pos_ext);
                    res_where   = pos_ext;
                    used_next   = CNT_W'(used_reg - 1'b1);
                end
            end
            OP_LOCATE:
            begin
                if (found)
                    res_where = match_idx;
                else
                begin
                    res_status = ST_NOT_FOUND;
                    res_where  = used_ext;
                end
            end
            OP_RETRIEVE:
            begin
                if (pos_ext >= used_ext)
                    res_status = ST_BAD_POS;
                else
                begin
                    res_rd    = rd_sel;
                    res_where = pos_ext;
                end
            end
            OP_CLEAR:
            begin
                used_next = '0;
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    assign ctl.op     = exec_go ? res_cell_op : CELL_HOLD;
    assign ctl.cmp_en = (state_reg == S_CMP);
    assign ctl.target = res_target;
    assign ctl.data   = value_reg;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    if (op_t'(s_axis_tdata[2:0]) == OP_SORTED ||
                        op_t'(s_axis_tdata[2:0]) == OP_LOCATE)
                        state_next = S_CMP;
                    else
                        state_next = S_EXEC;
                end
            end
            S_CMP:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (in_beat)
                begin
                    if (op_t'(s_axis_tdata[2:0]) == OP_SORTED ||
                        op_t'(s_axis_tdata[2:0]) == OP_LOCATE)
                        state_next = S_CMP;
                    else
                        state_next = S_EXEC;
                end
                else if (exec_go)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_go)
            begin
                used_reg      <= used_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            op_reg    <= s_axis_tdata[2:0];
            value_reg <= s_axis_tdata[34:3];
            pos_reg   <= s_axis_tdata[39:35];
        end
        if (exec_go)
        begin
            out_status_reg <= res_status;
            out_rd_reg     <= res_rd;
            out_where_reg  <= POS_W'(res_where);
            out_count_reg  <= POS_W'(used_next);
            out_empty_reg  <= (used_next == '0);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_empty_reg, out_count_reg, out_where_reg,
                            out_rd_reg, out_status_reg};

    // ---------------- checks ----------------
    `SAL_ASSERT(a_used_bound, (used_reg <= CNT_W'(CAPACITY)), "count exceeds capacity")
    `SAL_ASSERT(a_cmp_then_exec, (state_reg == S_CMP) |=> (state_reg == S_EXEC),
                "compare not followed by execute")
    `SAL_ASSERT(a_exec_result, exec_go |=> m_axis_tvalid, "execute step lost its result")
    `SAL_ASSERT(a_used_step, (exec_go && op_t'(op_reg) != OP_CLEAR) |=>
                (used_reg == $past(used_reg) ||
                 used_reg == CNT_W'($past(used_reg) + 1'b1) ||
                 used_reg == CNT_W'($past(used_reg) - 1'b1)),
                "count moved by more than one")
    `SAL_ASSERT(a_no_accept_in_cmp, (state_reg == S_CMP) |-> !s_axis_tready,
                "beat taken during compare")

endmodule
